// File: rtl/alla_pkg.sv
// Shared types and constants for the address lease allocator.
// Used by every module of the block but alla_ram; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package alla_pkg;

   localparam int TIME_W   = 31;
   localparam int CLIENT_W = 16;
   localparam int ADDR_W   = 16;
   localparam int EXP_W    = 32;
   localparam int LEASE_W  = 30;
   localparam int POOL_W   = 11;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [1:0] {
      ST_FREE    = 2'd0,
      ST_OFFERED = 2'd1,
      ST_TAKEN   = 2'd2,
      ST_EXPIRED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      DEST_SELF      = 2'd0,
      DEST_BROADCAST = 2'd1,
      DEST_OTHER     = 2'd2,
      DEST_SPARE     = 2'd3
   } dest_type;

   typedef enum logic [1:0] {
      OP_DISCOVER = 2'd0,
      OP_REQUEST  = 2'd1,
      OP_OTHER    = 2'd2,
      OP_SPARE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_OFFER = 2'd0,
      KIND_ACK   = 2'd1,
      KIND_NAK   = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CLS_AGE     = 2'd0,
      CLS_OFFER   = 2'd1,
      CLS_RELEASE = 2'd2,
      CLS_CHECK   = 2'd3
   } class_type;

   typedef enum logic [1:0] {
      CSR_POOL_SIZE     = 2'd0,
      CSR_DEFAULT_LEASE = 2'd1,
      CSR_MAX_LEASE     = 2'd2,
      CSR_MIN_LEASE     = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_SWEEP,
      BK_WAIT,
      BK_FINISH
   } back_state_type;

   typedef struct packed {
      status_type           st;
      logic [CLIENT_W-1:0]  owner;
      logic [EXP_W-1:0]     expiry;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      class_type            cls;
      logic [TIME_W-1:0]    now;
      logic [CLIENT_W-1:0]  client;
      logic [ADDR_W-1:0]    addr;
      logic [EXP_W-1:0]     grant;
   } item_type;

endpackage
`default_nettype wire

// File: rtl/alla_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the lease table; no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module alla_ram #(
   parameter int DATA_W = 50,
   parameter int DEPTH  = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);
   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: rtl/alla_front.sv
// Front end: accepts request beats, classifies them and works out the granted expiry.
// Uses alla_pkg; feeds alla_fifo.
`timescale 1ns / 1ps
`default_nettype none
module alla_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [alla_pkg::TIME_W-1:0]   req_msg_time,
   input  wire logic [alla_pkg::CLIENT_W-1:0] req_client,
   input  wire logic [1:0]                    req_dest,
   input  wire logic [1:0]                    req_op,
   input  wire logic [alla_pkg::ADDR_W-1:0]   req_addr,
   input  wire logic [alla_pkg::TIME_W-1:0]   req_req_expiry,
   input  wire logic [alla_pkg::LEASE_W-1:0]  default_lease,
   input  wire logic [alla_pkg::LEASE_W-1:0]  max_lease,
   input  wire logic [alla_pkg::LEASE_W-1:0]  min_lease,
   output logic                               push,
   output alla_pkg::item_type                 push_item,
   input  wire logic                          fifo_full
);
   logic               valid_ff, valid_in;
   alla_pkg::item_type item_ff, item_in;
   logic               accept;
   logic signed [32:0] diff;
   logic               ge_min, le_max;
   logic [31:0]        now_ext;

   assign req_stall = valid_ff && fifo_full;
   assign accept    = req_valid && !req_stall;
   assign push      = valid_ff && !fifo_full;
   assign push_item = item_ff;
   assign valid_in  = accept || (valid_ff && !push);

   assign now_ext = {1'b0, req_msg_time};
   assign diff    = $signed({2'b00, req_req_expiry}) - $signed({2'b00, req_msg_time});
   assign ge_min  = diff >= $signed({3'b000, min_lease});
   assign le_max  = diff <= $signed({3'b000, max_lease});

   always_comb begin
      item_in        = item_ff;
      if (accept) begin
         item_in.now    = req_msg_time;
         item_in.client = req_client;
         item_in.addr   = req_addr;
         if (req_req_expiry == '0) begin
            item_in.grant = now_ext + {2'b00, default_lease};
         end else if (ge_min && le_max) begin
            item_in.grant = {1'b0, req_req_expiry};
         end else if (!ge_min) begin
            item_in.grant = now_ext + {2'b00, min_lease};
         end else begin
            item_in.grant = now_ext + {2'b00, max_lease};
         end
         item_in.cls = alla_pkg::CLS_AGE;
         case (alla_pkg::op_type'(req_op))
            alla_pkg::OP_DISCOVER: begin
               if (alla_pkg::dest_type'(req_dest) == alla_pkg::DEST_BROADCAST) begin
                  item_in.cls = alla_pkg::CLS_OFFER;
               end
            end
            alla_pkg::OP_REQUEST: begin
               case (alla_pkg::dest_type'(req_dest))
                  alla_pkg::DEST_SELF:      item_in.cls = alla_pkg::CLS_CHECK;
                  alla_pkg::DEST_BROADCAST: item_in.cls = alla_pkg::CLS_AGE;
                  default:                  item_in.cls = alla_pkg::CLS_RELEASE;
               endcase
            end
            default: item_in.cls = alla_pkg::CLS_AGE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end
endmodule
`default_nettype wire

// File: rtl/alla_fifo.sv
// Two-entry queue of classified messages between the front end and the table walker.
// Uses alla_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none
module alla_fifo (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire alla_pkg::item_type push_item,
   output logic              full,
   input  wire logic         pop,
   output logic              not_empty,
   output alla_pkg::item_type pop_item
);
   alla_pkg::item_type slot_ff [2];
   logic               rd_ptr_ff, rd_ptr_in;
   logic               wr_ptr_ff, wr_ptr_in;
   logic [1:0]         count_ff, count_in;

   assign full      = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
   assign wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule
`default_nettype wire

// File: rtl/alla_back.sv
// Table walker: clears the lease table after reset, then ages and searches it per message
// and commits the chosen entry. Uses alla_pkg and alla_ram.
`timescale 1ns / 1ps
`default_nettype none
module alla_back #(
   parameter int POOL_MAX = 1024
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [$clog2(POOL_MAX+1)-1:0]      pool_n,
   input  wire logic                               q_valid,
   input  wire alla_pkg::item_type                 q_item,
   output logic                                    q_pop,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [1:0]                              rsp_kind,
   output logic [alla_pkg::CLIENT_W-1:0]           rsp_to_client,
   output logic [alla_pkg::ADDR_W-1:0]             rsp_lease_addr,
   output logic [alla_pkg::EXP_W-1:0]              rsp_lease_expiry
);
   localparam int AW = $clog2(POOL_MAX);
   localparam int CW = $clog2(POOL_MAX + 1);
   localparam logic [CW-1:0] LAST_IDX = CW'(POOL_MAX - 1);

   alla_pkg::back_state_type state_ff, state_in;
   alla_pkg::item_type       cur_ff, cur_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     rd_valid_ff, rd_valid_in;
   logic [CW-1:0]            rd_num_ff, rd_num_in;
   logic                     own_ok_ff, own_ok_in, free_ok_ff, free_ok_in;
   logic                     exp_ok_ff, exp_ok_in, hit_ff, hit_in;
   logic [CW-1:0]            own_num_ff, own_num_in, free_num_ff, free_num_in;
   logic [CW-1:0]            exp_num_ff, exp_num_in;
   logic                     out_valid_ff, out_valid_in;
   logic [1:0]               kind_ff, kind_in;
   logic [alla_pkg::CLIENT_W-1:0] to_ff, to_in;
   logic [alla_pkg::ADDR_W-1:0]   laddr_ff, laddr_in;
   logic [alla_pkg::EXP_W-1:0]    lexp_ff, lexp_in;

   logic                     we, re;
   logic [AW-1:0]            wa, ra;
   alla_pkg::entry_type      wd, rd, aged;
   logic [CW-1:0]            rd_idx, wr_idx, sel_num;
   logic                     out_free, sel_ok;

   alla_ram #(.DATA_W(alla_pkg::ENTRY_W), .DEPTH(POOL_MAX)) u_ram (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (wa),
      .wr_data (wd),
      .rd_en   (re),
      .rd_addr (ra),
      .rd_data (rd)
   );

   assign out_free = !out_valid_ff || !rsp_stall;
   assign rd_idx   = cnt_ff - CW'(1);
   assign wr_idx   = rd_num_ff - CW'(1);
   assign ra       = rd_idx[AW-1:0];

   // Aging, then the release of the client's offers for a request to another server.
   always_comb begin
      aged = rd;
      if (rd.st == alla_pkg::ST_OFFERED && rd.expiry <= {1'b0, cur_ff.now}) begin
         aged = '0;
      end else if (rd.st == alla_pkg::ST_TAKEN && rd.expiry <= {1'b0, cur_ff.now}) begin
         aged.st     = alla_pkg::ST_EXPIRED;
         aged.expiry = '0;
      end
      if (cur_ff.cls == alla_pkg::CLS_RELEASE && aged.st == alla_pkg::ST_OFFERED &&
          aged.owner == cur_ff.client) begin
         aged = '0;
      end
   end

   always_comb begin
      sel_ok  = own_ok_ff || free_ok_ff || exp_ok_ff;
      sel_num = own_ok_ff ? own_num_ff : (free_ok_ff ? free_num_ff : exp_num_ff);
   end

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      cnt_in      = cnt_ff;
      rd_valid_in = 1'b0;
      rd_num_in   = rd_num_ff;
      own_ok_in   = own_ok_ff;
      free_ok_in  = free_ok_ff;
      exp_ok_in   = exp_ok_ff;
      hit_in      = hit_ff;
      own_num_in  = own_num_ff;
      free_num_in = free_num_ff;
      exp_num_in  = exp_num_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      kind_in     = kind_ff;
      to_in       = to_ff;
      laddr_in    = laddr_ff;
      lexp_in     = lexp_ff;
      q_pop       = 1'b0;
      we          = 1'b0;
      wa          = wr_idx[AW-1:0];
      wd          = aged;
      re          = 1'b0;

      if (rd_valid_ff) begin
         we = 1'b1;
         if (!own_ok_ff && aged.st != alla_pkg::ST_FREE && aged.owner == cur_ff.client) begin
            own_ok_in  = 1'b1;
            own_num_in = rd_num_ff;
         end
         if (!free_ok_ff && aged.st == alla_pkg::ST_FREE) begin
            free_ok_in  = 1'b1;
            free_num_in = rd_num_ff;
         end
         if (!exp_ok_ff && aged.st == alla_pkg::ST_EXPIRED) begin
            exp_ok_in  = 1'b1;
            exp_num_in = rd_num_ff;
         end
         if ({{(alla_pkg::ADDR_W){1'b0}}, rd_num_ff} == {{CW{1'b0}}, cur_ff.addr} &&
             aged.owner == cur_ff.client) begin
            hit_in = 1'b1;
         end
      end

      case (state_ff)
         alla_pkg::BK_CLEAR: begin
            we     = 1'b1;
            wa     = cnt_ff[AW-1:0];
            wd     = '0;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == LAST_IDX) begin
               state_in = alla_pkg::BK_IDLE;
            end
         end
         alla_pkg::BK_IDLE: begin
            if (q_valid) begin
               q_pop      = 1'b1;
               cur_in     = q_item;
               cnt_in     = CW'(1);
               own_ok_in  = 1'b0;
               free_ok_in = 1'b0;
               exp_ok_in  = 1'b0;
               hit_in     = 1'b0;
               state_in   = (pool_n == '0) ? alla_pkg::BK_FINISH : alla_pkg::BK_SWEEP;
            end
         end
         alla_pkg::BK_SWEEP: begin
            re          = 1'b1;
            rd_valid_in = 1'b1;
            rd_num_in   = cnt_ff;
            cnt_in      = cnt_ff + CW'(1);
            if (cnt_ff == pool_n) begin
               state_in = alla_pkg::BK_WAIT;
            end
         end
         alla_pkg::BK_WAIT: begin
            state_in = alla_pkg::BK_FINISH;
         end
         alla_pkg::BK_FINISH: begin
            case (cur_ff.cls)
               alla_pkg::CLS_OFFER: begin
                  if (!sel_ok) begin
                     state_in = alla_pkg::BK_IDLE;
                  end else if (out_free) begin
                     we           = 1'b1;
                     wa           = AW'(sel_num - CW'(1));
                     wd.st        = alla_pkg::ST_OFFERED;
                     wd.owner     = cur_ff.client;
                     wd.expiry    = cur_ff.grant;
                     out_valid_in = 1'b1;
                     kind_in      = alla_pkg::KIND_OFFER;
                     to_in        = cur_ff.client;
                     laddr_in     = alla_pkg::ADDR_W'(sel_num);
                     lexp_in      = cur_ff.grant;
                     state_in     = alla_pkg::BK_IDLE;
                  end
               end
               alla_pkg::CLS_CHECK: begin
                  if (out_free) begin
                     out_valid_in = 1'b1;
                     to_in        = cur_ff.client;
                     laddr_in     = cur_ff.addr;
                     if (hit_ff) begin
                        we       = 1'b1;
                        wa       = AW'(cur_ff.addr - alla_pkg::ADDR_W'(1));
                        wd.st    = alla_pkg::ST_TAKEN;
                        wd.owner = cur_ff.client;
                        wd.expiry = cur_ff.grant;
                        kind_in  = alla_pkg::KIND_ACK;
                        lexp_in  = cur_ff.grant;
                     end else begin
                        kind_in  = alla_pkg::KIND_NAK;
                        lexp_in  = '0;
                     end
                     state_in = alla_pkg::BK_IDLE;
                  end
               end
               default: state_in = alla_pkg::BK_IDLE;
            endcase
         end
         default: state_in = alla_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= alla_pkg::BK_CLEAR;
         cnt_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff      <= cur_in;
      rd_num_ff   <= rd_num_in;
      own_ok_ff   <= own_ok_in;
      free_ok_ff  <= free_ok_in;
      exp_ok_ff   <= exp_ok_in;
      hit_ff      <= hit_in;
      own_num_ff  <= own_num_in;
      free_num_ff <= free_num_in;
      exp_num_ff  <= exp_num_in;
      kind_ff     <= kind_in;
      to_ff       <= to_in;
      laddr_ff    <= laddr_in;
      lexp_ff     <= lexp_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_to_client    = to_ff;
   assign rsp_lease_addr   = laddr_ff;
   assign rsp_lease_expiry = lexp_ff;
endmodule
`default_nettype wire

// File: rtl/address_lease_allocator_top.sv
// Address lease allocator: a DHCP-style lease table over addresses 1..pool_size.
// The lease table lives in one RAM of POOL_MAX entries that is cleared after reset, while
// messages are queued but not yet walked. Every message then walks the whole table once,
// one entry per cycle through the single RAM read port, aging each entry and noting
// candidates; a message passes through the sweep, wait and finish states (straight to
// finish when the pool is empty) and may wait in finish until the previous reply beat is
// taken. A two-deep queue behind the input register lets three more messages be accepted
// while the walk runs, and a reply that waits on rsp_stall does not hold back the next walk
// until that message is ready to reply. Configuration writes are meant for an idle block.
// Uses alla_pkg, alla_front, alla_fifo and alla_back.
`timescale 1ns / 1ps
`default_nettype none
module address_lease_allocator_top #(
   parameter int POOL_MAX = 1024
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_en,
   input  wire logic [alla_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [alla_pkg::LEASE_W-1:0]       csr_wdata,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [alla_pkg::TIME_W-1:0]        req_msg_time,
   input  wire logic [alla_pkg::CLIENT_W-1:0]      req_client,
   input  wire logic [1:0]                         req_dest,
   input  wire logic [1:0]                         req_op,
   input  wire logic [alla_pkg::ADDR_W-1:0]        req_addr,
   input  wire logic [alla_pkg::TIME_W-1:0]        req_req_expiry,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [1:0]                              rsp_kind,
   output logic [alla_pkg::CLIENT_W-1:0]           rsp_to_client,
   output logic [alla_pkg::ADDR_W-1:0]             rsp_lease_addr,
   output logic [alla_pkg::EXP_W-1:0]              rsp_lease_expiry
);
   localparam int CW = $clog2(POOL_MAX + 1);
   localparam int NW = (CW > alla_pkg::POOL_W) ? CW : alla_pkg::POOL_W;

   logic [alla_pkg::POOL_W-1:0]  pool_size_ff;
   logic [alla_pkg::LEASE_W-1:0] default_lease_ff, max_lease_ff, min_lease_ff;
   logic [CW-1:0]                pool_n;
   logic [NW-1:0]                pool_wide;

   logic               push, fifo_full, pop, not_empty;
   alla_pkg::item_type push_item, pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff     <= alla_pkg::POOL_W'(1024);
         default_lease_ff <= alla_pkg::LEASE_W'(60);
         max_lease_ff     <= alla_pkg::LEASE_W'(3600);
         min_lease_ff     <= alla_pkg::LEASE_W'(10);
      end else if (csr_write_en) begin
         case (alla_pkg::csr_index_type'(csr_index))
            alla_pkg::CSR_POOL_SIZE:     pool_size_ff     <= csr_wdata[alla_pkg::POOL_W-1:0];
            alla_pkg::CSR_DEFAULT_LEASE: default_lease_ff <= csr_wdata;
            alla_pkg::CSR_MAX_LEASE:     max_lease_ff     <= csr_wdata;
            alla_pkg::CSR_MIN_LEASE:     min_lease_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A pool size beyond the table acts as the table size.
   assign pool_wide = NW'(pool_size_ff);
   assign pool_n    = (pool_wide > NW'(POOL_MAX)) ? CW'(POOL_MAX) : CW'(pool_wide);

   alla_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_msg_time   (req_msg_time),
      .req_client     (req_client),
      .req_dest       (req_dest),
      .req_op         (req_op),
      .req_addr       (req_addr),
      .req_req_expiry (req_req_expiry),
      .default_lease  (default_lease_ff),
      .max_lease      (max_lease_ff),
      .min_lease      (min_lease_ff),
      .push           (push),
      .push_item      (push_item),
      .fifo_full      (fifo_full)
   );

   alla_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (fifo_full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_item  (pop_item)
   );

   alla_back #(.POOL_MAX(POOL_MAX)) u_back (
      .clock            (clock),
      .reset            (reset),
      .pool_n           (pool_n),
      .q_valid          (not_empty),
      .q_item           (pop_item),
      .q_pop            (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_to_client    (rsp_to_client),
      .rsp_lease_addr   (rsp_lease_addr),
      .rsp_lease_expiry (rsp_lease_expiry)
   );
endmodule
`default_nettype wire

// File: rtl/alla_checker.sv
// Port-level checks for the address lease allocator, bound to the top level.
// Uses alla_pkg for the reply codes.
`timescale 1ns / 1ps
`default_nettype none
module alla_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_kind,
   input wire logic [15:0] rsp_lease_addr,
   input wire logic [31:0] rsp_lease_expiry
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_lease_expiry))
      else $error("reply beat changed while stalled");

   a_nak_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == alla_pkg::KIND_NAK |-> rsp_lease_expiry == '0)
      else $error("negative acknowledge carries an expiry");

   a_offer_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == alla_pkg::KIND_OFFER |-> rsp_lease_addr != '0)
      else $error("offer of address zero");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("reply beat right after reset");
endmodule

bind address_lease_allocator_top alla_checker u_alla_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_lease_addr   (rsp_lease_addr),
   .rsp_lease_expiry (rsp_lease_expiry)
);
`default_nettype wire

// File: dv/address_lease_allocator_top_tb.sv
// Self-checking testbench for address_lease_allocator_top: directed and random lease traffic.
// A scoreboard class keeps its own lease table to predict every reply beat.
// Depends on alla_pkg and the RTL of the block.
`timescale 1ns / 1ps
`default_nettype none
module address_lease_allocator_top_tb;

   localparam int POOL_MAX   = 1024;
   // Up to four walks without a reply can still be in flight once all replies are in.
   localparam int DRAIN_WAIT = 5 * (POOL_MAX + 4) + 16;
   localparam int WATCHDOG   = 30000;
   localparam logic [29:0] LEASE_TOP = 30'h3FFF_FFFF;

   typedef logic [alla_pkg::TIME_W-1:0]   time_val_type;
   typedef logic [alla_pkg::CLIENT_W-1:0] client_type;
   typedef logic [alla_pkg::ADDR_W-1:0]   addr_type;
   typedef logic [alla_pkg::EXP_W-1:0]    expiry_type;
   typedef logic [alla_pkg::LEASE_W-1:0]  lease_type;
   typedef logic [1:0]                    code_type;

   typedef struct {
      time_val_type msg_time;
      client_type   client;
      code_type     dest;
      code_type     op;
      addr_type     addr;
      time_val_type want;
   } lease_msg_type;

   typedef struct {
      alla_pkg::kind_type kind;
      client_type         to_client;
      addr_type           lease_addr;
      expiry_type         lease_expiry;
   } lease_reply_type;

   class lease_scoreboard;
      alla_pkg::status_type status_tbl[POOL_MAX+1];
      client_type           owner_tbl[POOL_MAX+1];
      expiry_type           expiry_tbl[POOL_MAX+1];
      int unsigned          pool_size, dflt_lease, max_lease, min_lease;
      lease_reply_type      pending_replies[$];
      int                   mismatches;
      int                   replies_seen, offers, acks, naks;

      function new();
         pool_size  = 1024;
         dflt_lease = 60;
         max_lease  = 3600;
         min_lease  = 10;
         mismatches = 0;
         for (int i = 0; i <= POOL_MAX; i++) begin
            status_tbl[i] = alla_pkg::ST_FREE;
            owner_tbl[i]  = '0;
            expiry_tbl[i] = '0;
         end
      endfunction

      function void write_reg(alla_pkg::csr_index_type idx, lease_type val);
         case (idx)
            alla_pkg::CSR_POOL_SIZE:     pool_size  = 32'(val[alla_pkg::POOL_W-1:0]);
            alla_pkg::CSR_DEFAULT_LEASE: dflt_lease = 32'(val);
            alla_pkg::CSR_MAX_LEASE:     max_lease  = 32'(val);
            alla_pkg::CSR_MIN_LEASE:     min_lease  = 32'(val);
            default: ;
         endcase
      endfunction

      function int unsigned live_count();
         return (pool_size > POOL_MAX) ? POOL_MAX : pool_size;
      endfunction

      function expiry_type granted_expiry(time_val_type now, time_val_type want);
         longint d;
         if (want == 0) return {1'b0, now} + dflt_lease;
         d = longint'(want) - longint'(now);
         if (longint'(min_lease) <= d && d <= longint'(max_lease)) return {1'b0, want};
         if (d < longint'(min_lease)) return {1'b0, now} + min_lease;
         return {1'b0, now} + max_lease;
      endfunction

      // Lowest address the client holds in any non-free state, 0 if none.
      function int unsigned held_addr(client_type client);
         for (int i = 1; i <= live_count(); i++)
            if (status_tbl[i] != alla_pkg::ST_FREE && owner_tbl[i] == client) return i;
         return 0;
      endfunction

      function void note_request(lease_msg_type m);
         int unsigned n, sel;
         lease_reply_type r;
         n = live_count();
         for (int i = 1; i <= n; i++) begin
            if (status_tbl[i] == alla_pkg::ST_OFFERED &&
                expiry_tbl[i] <= {1'b0, m.msg_time}) begin
               status_tbl[i] = alla_pkg::ST_FREE;
               owner_tbl[i]  = '0;
               expiry_tbl[i] = '0;
            end else if (status_tbl[i] == alla_pkg::ST_TAKEN &&
                         expiry_tbl[i] <= {1'b0, m.msg_time}) begin
               status_tbl[i] = alla_pkg::ST_EXPIRED;
               expiry_tbl[i] = '0;
            end
         end
         r.to_client = m.client;
         if (m.op == alla_pkg::OP_DISCOVER) begin
            if (m.dest != alla_pkg::DEST_BROADCAST) return;
            sel = held_addr(m.client);
            for (int i = 1; i <= n && sel == 0; i++)
               if (status_tbl[i] == alla_pkg::ST_FREE) sel = i;
            for (int i = 1; i <= n && sel == 0; i++)
               if (status_tbl[i] == alla_pkg::ST_EXPIRED) sel = i;
            if (sel == 0) return;
            status_tbl[sel] = alla_pkg::ST_OFFERED;
            owner_tbl[sel]  = m.client;
            expiry_tbl[sel] = granted_expiry(m.msg_time, m.want);
            r.kind = alla_pkg::KIND_OFFER;
            r.lease_addr = sel[alla_pkg::ADDR_W-1:0];
            r.lease_expiry = expiry_tbl[sel];
            pending_replies.push_back(r);
            return;
         end
         if (m.op != alla_pkg::OP_REQUEST || m.dest == alla_pkg::DEST_BROADCAST) return;
         if (m.dest != alla_pkg::DEST_SELF) begin
            // Declined offer: the client took a lease elsewhere.
            for (int i = 1; i <= n; i++)
               if (owner_tbl[i] == m.client && status_tbl[i] == alla_pkg::ST_OFFERED) begin
                  status_tbl[i] = alla_pkg::ST_FREE;
                  owner_tbl[i]  = '0;
                  expiry_tbl[i] = '0;
               end
            return;
         end
         r.lease_addr = m.addr;
         if (m.addr >= 1 && m.addr <= n && owner_tbl[m.addr] == m.client) begin
            status_tbl[m.addr] = alla_pkg::ST_TAKEN;
            expiry_tbl[m.addr] = granted_expiry(m.msg_time, m.want);
            r.kind = alla_pkg::KIND_ACK;
            r.lease_expiry = expiry_tbl[m.addr];
         end else begin
            r.kind = alla_pkg::KIND_NAK;
            r.lease_expiry = '0;
         end
         pending_replies.push_back(r);
      endfunction

      function void check_reply(lease_reply_type got);
         lease_reply_type exp_r;
         replies_seen++;
         if (pending_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected reply beat kind=%0d client=%0d addr=%0d exp=%0d",
                        got.kind, got.to_client, got.lease_addr, got.lease_expiry);
            return;
         end
         exp_r = pending_replies.pop_front();
         case (exp_r.kind)
            alla_pkg::KIND_OFFER: offers++;
            alla_pkg::KIND_ACK:   acks++;
            default:              naks++;
         endcase
         if (got.kind !== exp_r.kind || got.to_client !== exp_r.to_client ||
             got.lease_addr !== exp_r.lease_addr || got.lease_expiry !== exp_r.lease_expiry)
            begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: reply mismatch expected kind=%0d client=%0d addr=%0d exp=%0d",
                        exp_r.kind, exp_r.to_client, exp_r.lease_addr, exp_r.lease_expiry);
               $display("       got kind=%0d client=%0d addr=%0d exp=%0d",
                        got.kind, got.to_client, got.lease_addr, got.lease_expiry);
            end
         end
      endfunction
   endclass

   logic                           clock, reset;
   logic                           csr_write_en;
   logic [alla_pkg::CSR_IDX_W-1:0] csr_index;
   lease_type                      csr_wdata;
   logic                           req_valid, req_stall;
   time_val_type                   req_msg_time, req_req_expiry;
   client_type                     req_client;
   code_type                       req_dest, req_op;
   addr_type                       req_addr;
   logic                           rsp_valid, rsp_stall;
   code_type                       rsp_kind;
   client_type                     rsp_to_client;
   addr_type                       rsp_lease_addr;
   expiry_type                     rsp_lease_expiry;

   address_lease_allocator_top #(.POOL_MAX(POOL_MAX)) DUT (.*);

   lease_scoreboard sb = new();
   time_val_type    clock_now;
   int              msgs_sent;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic write_csr(alla_pkg::csr_index_type idx, lease_type val);
      @(negedge clock);
      req_valid    = 1'b0;
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = val;
      @(posedge clock);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic send_msg(lease_msg_type m);
      @(negedge clock);
      req_msg_time   = m.msg_time;
      req_client     = m.client;
      req_dest       = m.dest;
      req_op         = m.op;
      req_addr       = m.addr;
      req_req_expiry = m.want;
      req_valid      = 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_request(m);
      msgs_sent++;
   endtask

   task automatic idle_gap(int cycles);
      @(negedge clock);
      req_valid = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Waits for every reply, then long enough for the walks that yield no reply.
   task automatic drain();
      idle_gap(0);
      while (sb.pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic configure(int unsigned pool, int unsigned dflt, int unsigned mx,
                            int unsigned mn);
      drain();
      write_csr(alla_pkg::CSR_POOL_SIZE, lease_type'(pool));
      write_csr(alla_pkg::CSR_DEFAULT_LEASE, lease_type'(dflt));
      write_csr(alla_pkg::CSR_MAX_LEASE, lease_type'(mx));
      write_csr(alla_pkg::CSR_MIN_LEASE, lease_type'(mn));
   endtask

   function automatic lease_msg_type make_msg(client_type client, code_type dest,
                                              code_type op, addr_type addr,
                                              time_val_type want);
      lease_msg_type m;
      m.msg_time = clock_now;
      m.client = client;
      m.dest = dest;
      m.op = op;
      m.addr = addr;
      m.want = want;
      return m;
   endfunction

   function automatic time_val_type pick_want();
      longint w;
      case ($urandom_range(0, 5))
         0: return '0;
         1: return time_val_type'($urandom());
         2: w = longint'(clock_now) - longint'($urandom_range(0, 50));
         default: w = longint'(clock_now) + longint'($urandom_range(0, 5000));
      endcase
      if (w < 0) w = 0;
      if (w > 64'h7FFF_FFFF) w = 64'h7FFF_FFFF;
      return w[alla_pkg::TIME_W-1:0];
   endfunction

   task automatic advance_time();
      longint t;
      case ($urandom_range(0, 9))
         0, 1, 2: t = clock_now;
         3, 4, 5, 6: t = longint'(clock_now) + longint'($urandom_range(1, 20));
         7, 8: t = longint'(clock_now) + longint'($urandom_range(1, 300));
         default: t = longint'(clock_now) + longint'($urandom_range(1, 6000));
      endcase
      if (t > 64'h7FFF_FFFF) t = 64'h7FFF_FFFF;
      clock_now = t[alla_pkg::TIME_W-1:0];
   endtask

   // Mostly discover then request sequences from a few clients, plus noise.
   task automatic random_phase(int count, time_val_type base);
      lease_msg_type m;
      client_type    c;
      int unsigned   held;
      int            burst;
      if (clock_now < base) clock_now = base;
      burst = $urandom_range(1, 12);
      for (int k = 0; k < count; k++) begin
         advance_time();
         c = ($urandom_range(0, 9) == 0) ? client_type'($urandom())
                                         : client_type'($urandom_range(1, 7));
         held = sb.held_addr(c);
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7:
               m = make_msg(c, alla_pkg::DEST_BROADCAST, alla_pkg::OP_DISCOVER,
                            addr_type'($urandom()), pick_want());
            8, 9, 10, 11, 12, 13:
               m = make_msg(c, alla_pkg::DEST_SELF, alla_pkg::OP_REQUEST,
                            (held != 0 && $urandom_range(0, 3) != 0) ? addr_type'(held)
                                : addr_type'($urandom_range(0, sb.live_count() + 1)),
                            pick_want());
            14, 15:
               m = make_msg(c, ($urandom_range(0, 1) != 0) ? alla_pkg::DEST_OTHER
                                                           : alla_pkg::DEST_SPARE,
                            alla_pkg::OP_REQUEST, addr_type'($urandom()), pick_want());
            default:
               m = make_msg(client_type'($urandom()), code_type'($urandom()),
                            code_type'($urandom()), addr_type'($urandom()),
                            time_val_type'($urandom()));
         endcase
         send_msg(m);
         if (--burst == 0) begin
            if ($urandom_range(0, 29) == 0) drain();
            else idle_gap($urandom_range(0, 6));
            burst = $urandom_range(1, 12);
         end
      end
   endtask

   // Reply side: a random stall pattern that switches between four modes.
   initial begin
      int mode;
      rsp_stall = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(50, 300)) begin
            @(negedge clock);
            case (mode)
               0: rsp_stall = 1'b0;
               1: rsp_stall = ($urandom_range(0, 3) == 0);
               2: rsp_stall = ($urandom_range(0, 9) < 8);
               default: rsp_stall = ~rsp_stall;
            endcase
         end
      end
   end

   initial begin
      lease_reply_type got;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            got.kind = alla_pkg::kind_type'(rsp_kind);
            got.to_client = rsp_to_client;
            got.lease_addr = rsp_lease_addr;
            got.lease_expiry = rsp_lease_expiry;
            sb.check_reply(got);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
         if (quiet >= WATCHDOG) begin
            $display("Watchdog: no beat accepted for %0d cycles", WATCHDOG);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_msg_time = '0;
      req_client = '0;
      req_dest = '0;
      req_op = '0;
      req_addr = '0;
      req_req_expiry = '0;
      clock_now = '0;
      msgs_sent = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part with the reset configuration.
      send_msg(make_msg(16'd1, alla_pkg::DEST_BROADCAST, alla_pkg::OP_DISCOVER, '0, '0));
      send_msg(make_msg(16'd1, alla_pkg::DEST_SELF, alla_pkg::OP_REQUEST, 16'd1, '0));
      send_msg(make_msg(16'd2, alla_pkg::DEST_SELF, alla_pkg::OP_REQUEST, 16'd0, '0));
      send_msg(make_msg(16'd2, alla_pkg::DEST_SELF, alla_pkg::OP_REQUEST, 16'd1025, '0));
      send_msg(make_msg(16'd0, alla_pkg::DEST_SELF, alla_pkg::OP_REQUEST, 16'd5, '0));
      send_msg(make_msg(16'd3, alla_pkg::DEST_SELF, alla_pkg::OP_DISCOVER, '0, '0));
      send_msg(make_msg(16'd3, alla_pkg::DEST_BROADCAST, alla_pkg::OP_REQUEST, 16'd1, '0));
      send_msg(make_msg(16'd3, alla_pkg::DEST_BROADCAST, alla_pkg::OP_OTHER, 16'd1, '0));
      send_msg(make_msg(16'd3, alla_pkg::DEST_BROADCAST, alla_pkg::OP_SPARE, 16'd1, '0));
      send_msg(make_msg(16'hFFFF, alla_pkg::DEST_BROADCAST, alla_pkg::OP_DISCOVER, 16'hFFFF,
                        31'd5));
      send_msg(make_msg(16'hFFFF, alla_pkg::DEST_SPARE, alla_pkg::OP_REQUEST, '0, '0));
      clock_now = 31'd100;
      send_msg(make_msg(16'd1, alla_pkg::DEST_SELF, alla_pkg::OP_REQUEST, 16'd1,
                        31'h7FFF_FFFF));
      send_msg(make_msg(16'd4, alla_pkg::DEST_BROADCAST, alla_pkg::OP_DISCOVER, '0, 31'd150));

      // Two-entry pool: exhaustion, reuse of expired entries, lease extremes.
      configure(2, 1, LEASE_TOP, 1);
      clock_now = 31'd1000;
      send_msg(make_msg(16'd10, alla_pkg::DEST_BROADCAST, alla_pkg::OP_DISCOVER, '0, '0));
      send_msg(make_msg(16'd11, alla_pkg::DEST_BROADCAST, alla_pkg::OP_DISCOVER, '0,
                        31'd2000));
      send_msg(make_msg(16'd12, alla_pkg::DEST_BROADCAST, alla_pkg::OP_DISCOVER, '0, '0));
      send_msg(make_msg(16'd11, alla_pkg::DEST_SELF, alla_pkg::OP_REQUEST, 16'd2, 31'd1001));
      send_msg(make_msg(16'd10, alla_pkg::DEST_SELF, alla_pkg::OP_REQUEST, 16'd1, 31'd900));
      clock_now = 31'd1002;
      send_msg(make_msg(16'd12, alla_pkg::DEST_BROADCAST, alla_pkg::OP_DISCOVER, '0, '0));
      send_msg(make_msg(16'd13, alla_pkg::DEST_BROADCAST, alla_pkg::OP_DISCOVER, '0, '0));
      send_msg(make_msg(16'd11, alla_pkg::DEST_SELF, alla_pkg::OP_REQUEST, 16'd2, '0));

      configure(8, 60, 3600, 10);
      random_phase(120, 31'd5000);
      configure(3, 1, 1, 1);
      random_phase(80, 31'd100000);
      configure(16, LEASE_TOP, LEASE_TOP, LEASE_TOP);
      random_phase(80, 31'h0100_0000);
      configure(5, 100, 5, 50);
      random_phase(80, 31'h0200_0000);
      configure(0, 60, 3600, 10);
      random_phase(30, 31'h0300_0000);
      configure(2047, 30, 200, 2);
      random_phase(25, 31'h1000_0000);
      configure(1, 7, 40, 3);
      random_phase(60, 31'h4000_0000);
      configure(12, 200, 500, 20);
      random_phase(100, 31'h7FFE_0000);

      drain();
      $display("Run covered %0d messages over pool sizes 0 to 2047 and lease extremes;",
               msgs_sent);
      $display("replies checked: %0d (%0d offers, %0d acks, %0d naks), mismatches: %0d",
               sb.replies_seen, sb.offers, sb.acks, sb.naks, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_replies.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
`default_nettype wire
